### design/baro_temp_compensation_unit_assert.svh
// Assertion helpers for the compensation unit.
`ifndef BARO_TEMP_COMPENSATION_UNIT_ASSERT_SVH
`define BARO_TEMP_COMPENSATION_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle.
`define BTC_ASSERT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Antecedent implies consequent in the following cycle.
`define BTC_ASSERT_NX(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`else

`define BTC_ASSERT(lbl, clk, rstn, ante, cons)
`define BTC_ASSERT_NX(lbl, clk, rstn, ante, cons)

`endif

`endif

### design/btc_pkg.sv
package btc_pkg;

    localparam int DIV_STAGES = 32;

    localparam logic [2:0] REG_TEMP_CALIB  = 3'd0;
    localparam logic [2:0] REG_PRESS_LOW   = 3'd1;
    localparam logic [2:0] REG_PRESS_HIGH  = 3'd2;
    localparam logic [2:0] REG_PRESS_LAST  = 3'd3;

    localparam logic [31:0] C_P_OFFSET   = 32'd64000;
    localparam logic [31:0] C_ADC_FULL   = 32'd1048576;
    localparam logic [31:0] C_P_SCALE    = 32'd3125;
    localparam logic [31:0] C_ONE_Q15    = 32'd32768;
    localparam logic [31:0] C_T_ROUND    = 32'd128;

    typedef struct packed {
        logic [23:0] raw_pressure;
        logic [23:0] raw_temperature;
    } t_btc_in;

    typedef struct packed {
        logic signed [15:0] temp_centideg;
        logic [31:0]        pressure_pa;
    } t_btc_out;

    // calibration words, already extended to 32 bits
    typedef struct packed {
        logic [31:0] t1;
        logic [31:0] t2;
        logic [31:0] t3;
        logic [31:0] p1;
        logic [31:0] p2;
        logic [31:0] p3;
        logic [31:0] p4;
        logic [31:0] p5;
        logic [31:0] p6;
        logic [31:0] p7;
        logic [31:0] p8;
        logic [31:0] p9;
    } t_calib;

    // front end to divider
    typedef struct packed {
        logic [31:0] num;
        logic [31:0] den;
        logic [15:0] temp;
        logic        post;   // quotient doubled afterwards
        logic        zero;   // divisor was zero
    } t_div_in;

    // divider to back end
    typedef struct packed {
        logic [31:0] quo;
        logic [15:0] temp;
        logic        post;
        logic        zero;
    } t_div_out;

    function automatic logic [31:0] sra(input logic [31:0] x, input int n);
        return 32'($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] mul_lo(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = {32'd0, a} * {32'd0, b};
        return p[31:0];
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

### design/btc_front.sv
module btc_front import btc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_valid,
    input  t_btc_in  i_data,
    input  t_calib   i_cal,
    output logic     o_valid,
    output t_div_in  o_div
);

    logic [10:0] r_v;

    // stage 1
    logic [31:0] r1_x1, r1_d;
    logic [19:0] r1_adc_p;
    // stage 2
    logic [31:0] r2_m1, r2_dd;
    logic [19:0] r2_adc_p;
    // stage 3
    logic [31:0] r3_a, r3_b0;
    logic [19:0] r3_adc_p;
    // stage 4
    logic [31:0] r4_fine;
    logic [19:0] r4_adc_p;
    // stage 5
    logic [31:0] r5_pa, r5_q;
    logic [15:0] r5_temp;
    logic [19:0] r5_adc_p;
    // stage 6
    logic [31:0] r6_qq, r6_ap5, r6_p2a;
    logic [15:0] r6_temp;
    logic [19:0] r6_adc_p;
    // stage 7
    logic [31:0] r7_b1, r7_p3q, r7_ap5, r7_p2a;
    logic [15:0] r7_temp;
    logic [19:0] r7_adc_p;
    // stage 8
    logic [31:0] r8_b, r8_a2;
    logic [15:0] r8_temp;
    logic [19:0] r8_adc_p;
    // stage 9
    logic [31:0] r9_b, r9_a3;
    logic [15:0] r9_temp;
    logic [19:0] r9_adc_p;
    // stage 10
    logic [31:0] r10_den, r10_pres;
    logic [15:0] r10_temp;
    // stage 11
    t_div_in     r11_out;

    logic [19:0] n_adc_t;
    logic [31:0] n5_fine5;
    logic [31:0] n5_pa;

    assign n_adc_t  = i_data.raw_temperature[23:4];
    assign n5_fine5 = (r4_fine << 2) + r4_fine + C_T_ROUND;
    assign n5_pa    = sra(r4_fine, 1) - C_P_OFFSET;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[9:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_x1    <= {15'd0, n_adc_t[19:3]} - (i_cal.t1 << 1);
            r1_d     <= {16'd0, n_adc_t[19:4]} - i_cal.t1;
            r1_adc_p <= i_data.raw_pressure[23:4];

            r2_m1    <= mul_lo(r1_x1, i_cal.t2);
            r2_dd    <= mul_lo(r1_d, r1_d);
            r2_adc_p <= r1_adc_p;

            r3_a     <= sra(r2_m1, 11);
            r3_b0    <= mul_lo(sra(r2_dd, 12), i_cal.t3);
            r3_adc_p <= r2_adc_p;

            r4_fine  <= r3_a + sra(r3_b0, 14);
            r4_adc_p <= r3_adc_p;

            r5_temp  <= n5_fine5[23:8];
            r5_pa    <= n5_pa;
            r5_q     <= sra(n5_pa, 2);
            r5_adc_p <= r4_adc_p;

            r6_qq    <= mul_lo(r5_q, r5_q);
            r6_ap5   <= mul_lo(r5_pa, i_cal.p5);
            r6_p2a   <= mul_lo(i_cal.p2, r5_pa);
            r6_temp  <= r5_temp;
            r6_adc_p <= r5_adc_p;

            r7_b1    <= mul_lo(sra(r6_qq, 11), i_cal.p6);
            r7_p3q   <= mul_lo(i_cal.p3, sra(r6_qq, 13));
            r7_ap5   <= r6_ap5;
            r7_p2a   <= r6_p2a;
            r7_temp  <= r6_temp;
            r7_adc_p <= r6_adc_p;

            r8_b     <= sra(r7_b1 + (r7_ap5 << 1), 2) + (i_cal.p4 << 16);
            r8_a2    <= sra(sra(r7_p3q, 3) + sra(r7_p2a, 1), 18);
            r8_temp  <= r7_temp;
            r8_adc_p <= r7_adc_p;

            r9_a3    <= mul_lo(C_ONE_Q15 + r8_a2, i_cal.p1);
            r9_b     <= r8_b;
            r9_temp  <= r8_temp;
            r9_adc_p <= r8_adc_p;

            r10_den  <= sra(r9_a3, 15);
            r10_pres <= mul_lo((C_ADC_FULL - {12'd0, r9_adc_p}) - sra(r9_b, 12), C_P_SCALE);
            r10_temp <= r9_temp;

            // small dividends are doubled before the division, large ones after
            r11_out.post <= r10_pres[31];
            r11_out.num  <= r10_pres[31] ? r10_pres : {r10_pres[30:0], 1'b0};
            r11_out.den  <= r10_den;
            r11_out.zero <= (r10_den == '0);
            r11_out.temp <= r10_temp;
        end
    end

    assign o_valid = r_v[10];
    assign o_div   = r11_out;

endmodule

### design/btc_div.sv
module btc_div import btc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_valid,
    input  t_div_in  i_div,
    output logic     o_valid,
    output t_div_out o_div
);

`include "baro_temp_compensation_unit_assert.svh"

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] work;   // dividend bits shift out, quotient bits shift in
        logic [31:0] den;
        logic [15:0] temp;
        logic        post;
        logic        zero;
    } t_div_slot;

    function automatic t_div_slot div_step(input t_div_slot x);
        t_div_slot   y;
        logic [32:0] trial;
        logic [32:0] diff;
        y     = x;
        trial = {x.rem, x.work[31]};
        diff  = trial - {1'b0, x.den};
        if (!diff[32]) begin
            y.rem  = diff[31:0];
            y.work = {x.work[30:0], 1'b1};
        end else begin
            y.rem  = trial[31:0];
            y.work = {x.work[30:0], 1'b0};
        end
        return y;
    endfunction

    t_div_slot             r_slot [DIV_STAGES];
    logic [DIV_STAGES-1:0] r_vld;
    t_div_slot             w_first;

    assign w_first.rem  = '0;
    assign w_first.work = i_div.num;
    assign w_first.den  = i_div.den;
    assign w_first.temp = i_div.temp;
    assign w_first.post = i_div.post;
    assign w_first.zero = i_div.zero;

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        if (s == 0) begin : g_head
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[s] <= 1'b0;
                end else if (i_en) begin
                    r_vld[s] <= i_valid;
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_slot[s] <= div_step(w_first);
                end
            end
        end else begin : g_body
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[s] <= 1'b0;
                end else if (i_en) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_slot[s] <= div_step(r_slot[s-1]);
                end
            end
        end
    end

    assign o_valid     = r_vld[DIV_STAGES-1];
    assign o_div.quo   = r_slot[DIV_STAGES-1].work;
    assign o_div.temp  = r_slot[DIV_STAGES-1].temp;
    assign o_div.post  = r_slot[DIV_STAGES-1].post;
    assign o_div.zero  = r_slot[DIV_STAGES-1].zero;

    `BTC_ASSERT(a_rem_below_den, i_clk, i_rst_n, r_vld[DIV_STAGES-1] && !r_slot[DIV_STAGES-1].zero, r_slot[DIV_STAGES-1].rem < r_slot[DIV_STAGES-1].den)
    `BTC_ASSERT_NX(a_head_loads, i_clk, i_rst_n, i_en && i_valid, r_vld[0])

endmodule

### design/btc_back.sv
module btc_back import btc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_valid,
    input  t_div_out i_div,
    input  t_calib   i_cal,
    output logic     o_valid,
    output t_btc_out o_data
);

`include "baro_temp_compensation_unit_assert.svh"

    logic [2:0]  r_v;
    logic [31:0] r1_q, r1_uu;
    logic [15:0] r1_temp;
    logic        r1_zero;
    logic [31:0] r2_q, r2_a, r2_b;
    logic [15:0] r2_temp;
    logic        r2_zero;
    t_btc_out    r3_out;
    logic        r3_zero;

    logic [31:0] n_q;
    logic [31:0] n_u;
    logic [31:0] n_sum;

    assign n_q   = i_div.post ? {i_div.quo[30:0], 1'b0} : i_div.quo;
    assign n_u   = n_q >> 3;
    assign n_sum = r2_a + r2_b + i_cal.p7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_q    <= n_q;
            r1_uu   <= mul_lo(n_u, n_u) >> 13;
            r1_temp <= i_div.temp;
            r1_zero <= i_div.zero;

            r2_a    <= sra(mul_lo(i_cal.p9, r1_uu), 12);
            r2_b    <= sra(mul_lo(r1_q >> 2, i_cal.p8), 13);
            r2_q    <= r1_q;
            r2_temp <= r1_temp;
            r2_zero <= r1_zero;

            r3_out.temp_centideg <= r2_temp;
            r3_out.pressure_pa   <= r2_zero ? '0 : r2_q + sra(n_sum, 4);
            r3_zero              <= r2_zero;
        end
    end

    assign o_valid = r_v[2];
    assign o_data  = r3_out;

    `BTC_ASSERT(a_zero_div_gives_zero, i_clk, i_rst_n, r_v[2] && r3_zero, r3_out.pressure_pa == '0)

endmodule

### design/baro_temp_compensation_unit.sv
// Stages: 11 front, 32 divider at one quotient bit each, 3 back (output register).
// Throughput: one item per cycle while the output is not stalled; the restoring
// divider pipeline sets the depth.
// A stall on the output freezes every stage at once, so nothing is lost or doubled.
// Reset (synchronous, active low) clears all valid bits and the calibration registers.
module baro_temp_compensation_unit import btc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_valid,
    output logic        o_stall,
    input  t_btc_in     i_data,
    // result items
    output logic        o_valid,
    input  logic        i_stall,
    output t_btc_out    o_data,
    // calibration register writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

`include "baro_temp_compensation_unit_assert.svh"

    // Calibration registers. The user must see that they are only written while the pipe is
    // empty (the block does not enforce it), so the stages read them directly without carrying copies along.
    logic [47:0] r_tcal;
    logic [63:0] r_pcal_lo;
    logic [63:0] r_pcal_hi;
    logic [15:0] r_pcal_last;

    t_calib      w_cal;
    logic        w_en;       // global advance for all stages
    logic        w_fr_valid;
    t_div_in     w_fr_div;
    logic        w_dv_valid;
    t_div_out    w_dv_div;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcal      <= '0;
            r_pcal_lo   <= '0;
            r_pcal_hi   <= '0;
            r_pcal_last <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_TEMP_CALIB: r_tcal      <= i_cfg_data[47:0];
                REG_PRESS_LOW:  r_pcal_lo   <= i_cfg_data;
                REG_PRESS_HIGH: r_pcal_hi   <= i_cfg_data;
                REG_PRESS_LAST: r_pcal_last <= i_cfg_data[15:0];
                default: ;      // unmapped index, write dropped
            endcase
        end
    end

    // unpack: T1 and P1 unsigned, the rest sign extended
    assign w_cal.t1 = {16'd0, r_tcal[15:0]};
    assign w_cal.t2 = sx16(r_tcal[31:16]);
    assign w_cal.t3 = sx16(r_tcal[47:32]);
    assign w_cal.p1 = {16'd0, r_pcal_lo[15:0]};
    assign w_cal.p2 = sx16(r_pcal_lo[31:16]);
    assign w_cal.p3 = sx16(r_pcal_lo[47:32]);
    assign w_cal.p4 = sx16(r_pcal_lo[63:48]);
    assign w_cal.p5 = sx16(r_pcal_hi[15:0]);
    assign w_cal.p6 = sx16(r_pcal_hi[31:16]);
    assign w_cal.p7 = sx16(r_pcal_hi[47:32]);
    assign w_cal.p8 = sx16(r_pcal_hi[63:48]);
    assign w_cal.p9 = sx16(r_pcal_last);

    // The pipe holds only when a finished item sits in the output register
    // and the sink stalls; otherwise everything moves one stage.
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    // fine temperature, temperature, pressure coefficients, divisor and dividend
    btc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_data  (i_data),
        .i_cal   (w_cal),
        .o_valid (w_fr_valid),
        .o_div   (w_fr_div)
    );

    // unsigned 32-bit division, one quotient bit per stage
    btc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fr_valid),
        .i_div   (w_fr_div),
        .o_valid (w_dv_valid),
        .o_div   (w_dv_div)
    );

    // second-order pressure correction and output register
    btc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_dv_valid),
        .i_div   (w_dv_div),
        .i_cal   (w_cal),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

    `BTC_ASSERT_NX(a_reset_empties_pipe, i_clk, 1'b1, !i_rst_n, !o_valid)

endmodule
